FILE: rtl/pbva_pkg.sv
// Shared types and constants for the per-space bump VA allocator.
// Used by the cell, the cell row and the top level; depends on nothing.
package pbva_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int PAGE_BYTES    = 4096;
    localparam int PAGE_SHIFT    = 12;

    localparam int ROOT_W  = 64;
    localparam int KEY_W   = ROOT_W - PAGE_SHIFT;
    localparam int ADDR_W  = 48;
    localparam int CUR_W   = 49;
    localparam int LEN_W   = 49;
    localparam int SIZE_W  = 50;
    localparam int PAGES_W = 37;
    localparam int STAT_W  = 3;
    localparam int MODE_W  = 2;

    localparam logic [CUR_W-1:0] END_CAP    = 49'h1_0000_0000_0000;
    localparam logic [CUR_W-1:0] BASE_RESET = 49'h0_0001_0000_0000;
    localparam logic [CUR_W-1:0] END_RESET  = 49'h0_8000_0000_0000;

    localparam logic [MODE_W-1:0] MODE_MAP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNMAP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BAD     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EXHAUST = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OOM     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_OUTSIDE = 3'd4;

    typedef struct packed {
        logic             stb;
        logic             en;
        logic             claim_ok;
        logic [KEY_W-1:0] key;
    } lookup_t;

    typedef struct packed {
        logic             hit;
        logic             free;
        logic [CUR_W-1:0] cursor;
    } chain_t;

    typedef struct packed {
        logic             valid;
        logic             set_key;
        logic             set_cur;
        logic [KEY_W-1:0] key;
        logic [CUR_W-1:0] cur;
    } cmd_t;

endpackage

FILE: rtl/per_space_bump_va_allocator.sv
// Top level of the per-space bump VA allocator: stream ports, APB registers,
// request sequencing and result checks. Uses pbva_pkg and pbva_row.
// Usage:
// A request word enters on s_t*: tuser carries the mode (map, release,
// unmap check), tdata the root, length, address and flags. Every request
// yields exactly one result word on m_t*: status, base address, page count,
// writable flag and shared-cursor flag.
// A map looks up the root's key in a row of 16 slot cells, claims the first
// free slot if the key is new, or falls back to one shared cursor when all
// slots are taken. A release frees the key's slot. An unmap check rejects a
// zero root, address or length and tests the address against the window.
// Steps: an accepted request passes the look step, the lookup through the
// cell row, and then the commit step, the bounds check and cursor update,
// which loads the output register. A new request is accepted while idle or
// in the commit step, on the cycle the result is loaded.
// A stalled m_tready holds the result in the output register and holds the
// block in its commit step, so s_tready stays low until the result moves.
// Reset (aresetn low, synchronous) empties all slots, loads the registers
// with their defaults and resets the shared cursor; no clearing pass.
// window_base and window_end are written over APB at 0x0 and 0x8.
module per_space_bump_va_allocator import pbva_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] as_root, [112:64] length, [160:113] address, [161] write_req,
    // [162] backing_ok, [167:163] zero
    input  logic [167:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [50:3] base_address, [87:51] page_count, [88] writable,
    // [89] shared_cursor, [95:90] zero
    output logic [95:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    localparam logic REG_WBASE = 1'b0;
    localparam logic REG_WEND  = 1'b1;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] wbase_reg;
    logic [CUR_W-1:0]  wend_reg;
    logic [CUR_W-1:0]  shared_next_reg;

    logic [MODE_W-1:0] req_mode_reg;
    logic [ROOT_W-1:0] req_root_reg;
    logic [LEN_W-1:0]  req_len_reg;
    logic [ADDR_W-1:0] req_addr_reg;
    logic              req_wr_reg;
    logic              req_ok_reg;

    logic [CUR_W-1:0]  base_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              shared_reg;
    logic              claim_reg;

    logic              m_tvalid_reg;
    logic [95:0]       m_tdata_reg;

    logic              accept;
    logic              commit;
    logic              cfg_wr;
    logic [KEY_W-1:0]  req_key;
    logic              map_args_ok;
    logic [SIZE_W-1:0] len_sum;
    logic [CUR_W-1:0]  wend;
    logic              exhaust;
    logic              success;
    logic [CUR_W-1:0]  next_cur;

    logic [STAT_W-1:0]  res_status;
    logic [ADDR_W-1:0]  res_base;
    logic [PAGES_W-1:0] res_pages;
    logic               res_wr;
    logic               res_sh;

    lookup_t lookup;
    cmd_t    cmd;
    chain_t  row_res;

    // ---- APB ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == REG_WEND) ? {15'd0, wend_reg} : {16'd0, wbase_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wbase_reg <= BASE_RESET[ADDR_W-1:0];
            wend_reg  <= END_RESET;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_WBASE) begin
                wbase_reg <= pwdata[ADDR_W-1:0];
            end else begin
                wend_reg <= pwdata[CUR_W-1:0];
            end
        end
    end

    // ---- sequencing ----
    assign commit   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_EXEC;
            ST_EXEC: begin
                if (commit) state_next = accept ? ST_LOOK : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_mode_reg <= s_tuser[1:0];
            req_root_reg <= s_tdata[63:0];
            req_len_reg  <= s_tdata[112:64];
            req_addr_reg <= s_tdata[160:113];
            req_wr_reg   <= s_tdata[161];
            req_ok_reg   <= s_tdata[162];
        end
    end

    // ---- lookup through the cell row ----
    assign req_key     = req_root_reg[ROOT_W-1:PAGE_SHIFT];
    assign map_args_ok = (req_root_reg != '0) && (req_len_reg != '0) && (req_key != '0);

    assign lookup.stb      = (state_reg == ST_LOOK);
    assign lookup.en       = ((req_mode_reg == MODE_MAP) && map_args_ok) ||
                             ((req_mode_reg == MODE_REL) && (req_key != '0));
    assign lookup.claim_ok = (req_mode_reg == MODE_MAP) && map_args_ok;
    assign lookup.key      = req_key;

    pbva_row u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .lookup  (lookup),
        .cmd     (cmd),
        .result  (row_res)
    );

    assign len_sum = {1'b0, req_len_reg} + SIZE_W'(PAGE_BYTES - 1);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOK) begin
            if (row_res.hit) begin
                base_reg <= row_res.cursor;
            end else if (row_res.free) begin
                base_reg <= {1'b0, wbase_reg};
            end else begin
                base_reg <= shared_next_reg;
            end
            shared_reg <= !row_res.hit && !row_res.free;
            claim_reg  <= !row_res.hit && row_res.free;
            size_reg   <= {len_sum[SIZE_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
        end
    end

    // ---- bounds check and update ----
    assign wend     = (wend_reg > END_CAP) ? END_CAP : wend_reg;
    assign exhaust  = (base_reg < {1'b0, wbase_reg}) || (base_reg >= wend) ||
                      (size_reg > ({1'b0, wend} - {1'b0, base_reg}));
    assign success  = map_args_ok && !exhaust && req_ok_reg;
    assign next_cur = CUR_W'({1'b0, base_reg} + size_reg);

    always_comb begin
        res_status = STAT_BAD;
        res_base   = '0;
        res_pages  = '0;
        res_wr     = 1'b0;
        res_sh     = 1'b0;
        cmd        = '0;
        unique case (req_mode_reg)
            MODE_MAP: begin
                if (map_args_ok) begin
                    res_sh      = shared_reg;
                    cmd.set_key = claim_reg;
                    cmd.key     = req_key;
                    cmd.set_cur = claim_reg || (success && !shared_reg);
                    cmd.cur     = success ? next_cur : {1'b0, wbase_reg};
                    if (exhaust) begin
                        res_status = STAT_EXHAUST;
                    end else if (!req_ok_reg) begin
                        res_status = STAT_OOM;
                    end else begin
                        res_status = STAT_OK;
                        res_base   = base_reg[ADDR_W-1:0];
                        res_pages  = size_reg[PAGE_SHIFT+PAGES_W-1:PAGE_SHIFT];
                        res_wr     = req_wr_reg;
                    end
                end
            end
            MODE_REL: begin
                res_status  = STAT_OK;
                cmd.set_key = 1'b1;
                cmd.set_cur = 1'b1;
            end
            MODE_UNMAP: begin
                if ((req_root_reg == '0) || (req_addr_reg == '0) || (req_len_reg == '0)) begin
                    res_status = STAT_BAD;
                end else if ((req_addr_reg < wbase_reg) || ({1'b0, req_addr_reg} >= wend)) begin
                    res_status = STAT_OUTSIDE;
                end else begin
                    res_status = STAT_OK;
                end
            end
            default: res_status = STAT_BAD;
        endcase
        cmd.valid = commit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shared_next_reg <= BASE_RESET;
        end else if (commit && (req_mode_reg == MODE_MAP) && success && shared_reg) begin
            shared_next_reg <= next_cur;
        end
    end

    // ---- output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_tdata_reg <= {6'd0, res_sh, res_wr, res_pages, res_base, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_accept_starts_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_LOOK))
        else $error("accepted word did not start a lookup");

    a_shared_not_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[89]) |-> (m_tdata[2:0] != STAT_BAD))
        else $error("shared cursor flagged on a rejected request");

    a_base_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[87:51] != '0)) |->
            ((m_tdata[50:3] >= wbase_reg) && (m_tdata[2:0] == STAT_OK)))
        else $error("granted region starts below the window");

    a_no_result_while_looking: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |=> !$rose(m_tvalid))
        else $error("result loaded before the commit step");
`endif

endmodule

FILE: rtl/pbva_cell.sv
// One table slot: an address-space key and its bump cursor.
// Passes hit, free and cursor data along the row; uses pbva_pkg.
module pbva_cell import pbva_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  lookup_t lookup,
    input  logic    any_hit,
    input  cmd_t    cmd,
    input  chain_t  chain_in,
    output chain_t  chain_out
);

    logic [KEY_W-1:0] key_reg;
    logic [CUR_W-1:0] cur_reg;
    logic             sel_reg;
    logic             sel_next;
    logic             is_free;
    logic             hit;
    logic             first_free;

    assign is_free    = (key_reg == '0);
    assign hit        = lookup.en && (key_reg == lookup.key);
    assign first_free = is_free && !chain_in.free;
    assign sel_next   = hit || (first_free && lookup.claim_ok && !any_hit);

    assign chain_out.hit    = chain_in.hit | hit;
    assign chain_out.free   = chain_in.free | is_free;
    assign chain_out.cursor = chain_in.cursor | (hit ? cur_reg : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            cur_reg <= '0;
            sel_reg <= 1'b0;
        end else begin
            if (lookup.stb) begin
                sel_reg <= sel_next;
            end
            if (cmd.valid && sel_reg) begin
                if (cmd.set_key) begin
                    key_reg <= cmd.key;
                end
                if (cmd.set_cur) begin
                    cur_reg <= cmd.cur;
                end
            end
        end
    end

endmodule

FILE: rtl/pbva_row.sv
// Row of pbva_cell slots chained from slot 0 upward.
// Returns the hit, free and cursor data at the row end; uses pbva_pkg.
module pbva_row import pbva_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  lookup_t lookup,
    input  cmd_t    cmd,
    output chain_t  result
);

    chain_t chain [TABLE_ENTRIES+1];

    assign chain[0] = '0;
    assign result   = chain[TABLE_ENTRIES];

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        pbva_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .lookup    (lookup),
            .any_hit   (chain[TABLE_ENTRIES].hit),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

endmodule

FILE: tb/sv/tb_per_space_bump_va_allocator.sv
// Testbench for per_space_bump_va_allocator: drives request words and APB writes,
// predicts every result word from its own copy of the slot table and cursors.
// Depends on pbva_pkg and the RTL of the allocator only.
`timescale 1ns / 1ps

module tb_per_space_bump_va_allocator import pbva_pkg::*;;

    localparam int REG_WINDOW_BASE = 0;
    localparam int REG_WINDOW_END  = 1;
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE   = 24;
    localparam logic [63:0] MASK49 = 64'h1_FFFF_FFFF_FFFF;
    localparam logic [LEN_W-1:0] LEN_MAX = 49'h1_0000_0000_0000;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic               writable;
        logic               shared;
    } alloc_result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [63:0]       root;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] address;
        logic              wr;
        logic              ok;
    } alloc_req_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    logic [KEY_W-1:0]  slot_key [TABLE_ENTRIES];
    logic [CUR_W-1:0]  slot_cur [TABLE_ENTRIES];
    logic [CUR_W-1:0]  shared_cur;
    logic [ADDR_W-1:0] win_base;
    logic [CUR_W-1:0]  win_end;

    alloc_result_t pending_results[$];
    alloc_result_t head_result;
    logic [63:0]   root_pool [POOL_SIZE];
    int fails = 0;
    int send_idle_pct = 8;
    int recv_idle_pct = 48;
    int stall_cycles = 0;
    int hold_count = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;

    per_space_bump_va_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    function automatic void model_reset();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_key[i] = '0;
            slot_cur[i] = '0;
        end
        shared_cur = BASE_RESET;
        win_base   = BASE_RESET[ADDR_W-1:0];
        win_end    = END_RESET;
    endfunction

    function automatic alloc_result_t predict_alloc(alloc_req_t r);
        alloc_result_t    res;
        logic [KEY_W-1:0] key;
        logic [63:0]      wend;
        logic [63:0]      size;
        logic [63:0]      cur;
        logic [63:0]      nxt;
        int               slot;
        res = '0;
        res.status = STAT_BAD;
        key = r.root[63:PAGE_SHIFT];
        wend = (win_end > END_CAP) ? 64'(END_CAP) : 64'(win_end);
        case (r.mode)
            MODE_MAP: begin
                if (r.root != 0 && r.length != 0 && key != 0) begin
                    size = (64'(r.length) + 64'(PAGE_BYTES - 1)) & ~64'(PAGE_BYTES - 1);
                    slot = -1;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (slot < 0 && slot_key[i] == key) slot = i;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (slot < 0 && slot_key[i] == 0) begin
                            slot = i;
                            slot_key[i] = key;
                            slot_cur[i] = CUR_W'(win_base);
                        end
                    end
                    cur = (slot >= 0) ? 64'(slot_cur[slot]) : 64'(shared_cur);
                    res.shared = (slot < 0);
                    if (cur < 64'(win_base) || cur >= wend || size > wend - cur) begin
                        res.status = STAT_EXHAUST;
                    end else if (!r.ok) begin
                        res.status = STAT_OOM;
                    end else begin
                        nxt = (cur + size) & MASK49;
                        if (slot >= 0) slot_cur[slot] = nxt[CUR_W-1:0];
                        else shared_cur = nxt[CUR_W-1:0];
                        res.status   = STAT_OK;
                        res.base     = cur[ADDR_W-1:0];
                        res.pages    = size[PAGE_SHIFT+PAGES_W-1:PAGE_SHIFT];
                        res.writable = r.wr;
                    end
                end
            end
            MODE_REL: begin
                res.status = STAT_OK;
                slot = -1;
                if (key != 0) begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (slot < 0 && slot_key[i] == key) slot = i;
                    if (slot >= 0) begin
                        slot_key[slot] = '0;
                        slot_cur[slot] = '0;
                    end
                end
            end
            MODE_UNMAP: begin
                if (r.root == 0 || r.address == 0 || r.length == 0)
                    res.status = STAT_BAD;
                else if (r.address < win_base || 64'(r.address) >= wend)
                    res.status = STAT_OUTSIDE;
                else
                    res.status = STAT_OK;
            end
            default: res.status = STAT_BAD;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            m_tready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count + 1 >= HOLD_CYCLES) hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no pending request: %h", m_tdata);
                fails++;
            end else begin
                head_result = pending_results.pop_front();
                if (m_tdata[2:0] !== head_result.status) begin
                    $error("status: expected %0d, got %0d", head_result.status, m_tdata[2:0]);
                    fails++;
                end
                if (m_tdata[50:3] !== head_result.base) begin
                    $error("base_address: expected %h, got %h", head_result.base, m_tdata[50:3]);
                    fails++;
                end
                if (m_tdata[87:51] !== head_result.pages) begin
                    $error("page_count: expected %h, got %h", head_result.pages, m_tdata[87:51]);
                    fails++;
                end
                if (m_tdata[88] !== head_result.writable) begin
                    $error("writable: expected %0d, got %0d", head_result.writable, m_tdata[88]);
                    fails++;
                end
                if (m_tdata[89] !== head_result.shared) begin
                    $error("shared_cursor: expected %0d, got %0d", head_result.shared, m_tdata[89]);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [63:0] root,
                             input logic [LEN_W-1:0] length, input logic [ADDR_W-1:0] address,
                             input logic wr, input logic ok);
        alloc_req_t req;
        req = '{mode, root, length, address, wr, ok};
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, ok, wr, address, length, root};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_alloc(req));
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input int idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 8);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WINDOW_BASE) win_base = value[ADDR_W-1:0];
        else win_end = value[CUR_W-1:0];
        @(posedge aclk);
    endtask

    task automatic reg_readback(input int idx);
        logic [63:0] want;
        want = (idx == REG_WINDOW_BASE) ? 64'(win_base) : 64'(win_end);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 4'(idx * 8);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want) begin
            $error("register %0d: expected %h, got %h", idx, want, prdata);
            fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_window(input logic [63:0] base, input logic [63:0] wend);
        wait_results_done();
        reg_write(REG_WINDOW_BASE, base);
        reg_write(REG_WINDOW_END, wend);
        reg_readback(REG_WINDOW_BASE);
        reg_readback(REG_WINDOW_END);
    endtask

    task automatic free_all_slots();
        logic [KEY_W-1:0] snap [TABLE_ENTRIES];
        snap = slot_key;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (snap[i] != 0)
                send_word(MODE_REL, {snap[i], 12'($urandom)}, LEN_W'($urandom),
                          ADDR_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic test_map_cases();
        send_word(MODE_MAP, 64'h0, 49'h1000, 48'h0, 1'b1, 1'b1);
        send_word(MODE_MAP, 64'hFFF, 49'h1000, 48'h0, 1'b1, 1'b1);
        send_word(MODE_MAP, 64'h0000_7A3C_1234_5000, 49'h0, 48'h0, 1'b1, 1'b1);
        send_word(MODE_MAP, 64'h0000_7A3C_1234_5000, 49'h1, 48'h0, 1'b1, 1'b1);
        send_word(MODE_MAP, 64'h0000_7A3C_1234_5ABC, 49'h1001, 48'h0, 1'b0, 1'b1);
        send_word(MODE_MAP, 64'h0000_7A3C_1234_5000, LEN_MAX, 48'h0, 1'b1, 1'b1);
        send_word(MODE_MAP, 64'h0000_7A3C_1234_5000, 49'h2000, 48'h0, 1'b1, 1'b0);
        send_word(MODE_MAP, 64'hFFFF_FFFF_FFFF_FFFF, 49'h0_0FFF_FFFF_FFFF,
                  48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
        send_word(MODE_MAP, 64'hFFFF_FFFF_FFFF_FFFF, 49'h1_FFFF_FFFF_FFFF, 48'h0, 1'b1, 1'b1);
    endtask

    task automatic test_release_unmap();
        send_word(MODE_REL, 64'h0123_4567_89AB_C000, 49'h0, 48'h0, 1'b0, 1'b0);
        send_word(MODE_REL, 64'hFFF, 49'h0, 48'h0, 1'b0, 1'b0);
        send_word(MODE_REL, 64'h0000_7A3C_1234_5FFF, 49'h0, 48'h0, 1'b0, 1'b0);
        send_word(MODE_MAP, 64'h0000_7A3C_1234_5000, 49'h3000, 48'h0, 1'b1, 1'b1);
        send_word(MODE_UNMAP, 64'h0, 49'h1000, 48'h1_0000_0000, 1'b0, 1'b1);
        send_word(MODE_UNMAP, 64'hFFF, 49'h1000, 48'h1_0000_0000, 1'b0, 1'b1);
        send_word(MODE_UNMAP, 64'h0000_7A3C_1234_5000, 49'h1000, 48'h0, 1'b0, 1'b1);
        send_word(MODE_UNMAP, 64'h0000_7A3C_1234_5000, 49'h0, 48'h1_0000_0000, 1'b0, 1'b1);
        send_word(MODE_UNMAP, 64'h0000_7A3C_1234_5000, 49'h1000, 48'h1000, 1'b0, 1'b1);
        send_word(MODE_UNMAP, 64'h0000_7A3C_1234_5000, 49'h1000, 48'h8000_0000_0000, 1'b0, 1'b1);
        send_word(MODE_UNMAP, 64'h0000_7A3C_1234_5000, LEN_MAX, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_word(MODE_UNMAP, 64'h0000_7A3C_1234_5000, 49'h1, 48'h1_0000_0000, 1'b1, 1'b1);
        send_word(MODE_RSVD, 64'hFFFF_FFFF_FFFF_FFFF, 49'h1_FFFF_FFFF_FFFF,
                  48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
    endtask

    task automatic test_table_full();
        free_all_slots();
        for (int i = 0; i < TABLE_ENTRIES + 3; i++)
            send_word(MODE_MAP, {32'h00C0_FFEE + 32'(i), 20'($urandom), 12'($urandom)},
                      49'($urandom_range(1, 20000)), 48'h0, 1'($urandom), 1'b1);
        send_word(MODE_MAP, 64'h0DEA_D000_0000_0000, 49'h1000, 48'h0, 1'b1, 1'b0);
        send_word(MODE_REL, {slot_key[5], 12'h123}, 49'h0, 48'h0, 1'b0, 1'b0);
        send_word(MODE_MAP, 64'h0DEA_D000_0000_0000, 49'h5000, 48'h0, 1'b1, 1'b1);
    endtask

    task automatic test_window_extremes();
        set_window(64'h0, 64'h0);
        free_all_slots();
        send_word(MODE_MAP, 64'h0000_0000_0000_1000, 49'h1, 48'h0, 1'b1, 1'b1);
        send_word(MODE_UNMAP, 64'h0000_0000_0000_1000, 49'h1, 48'h1, 1'b1, 1'b1);
        set_window(64'hFFFF_FFFF_FFFF, 64'h1_FFFF_FFFF_FFFF);
        free_all_slots();
        send_word(MODE_MAP, 64'h0000_0000_0000_2000, 49'h1, 48'h0, 1'b1, 1'b1);
        send_word(MODE_UNMAP, 64'h0000_0000_0000_2000, 49'h1, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
        send_word(MODE_UNMAP, 64'h0000_0000_0000_2000, 49'h1, 48'hFFFF_FFFF_FFFE, 1'b1, 1'b1);
        set_window(64'hFFFF_FFFF_F000, 64'h1_0000_0000_0000);
        free_all_slots();
        send_word(MODE_MAP, 64'h0000_0000_0000_3000, 49'h1000, 48'h0, 1'b1, 1'b1);
        send_word(MODE_MAP, 64'h0000_0000_0000_3000, 49'h1, 48'h0, 1'b1, 1'b1);
        set_window(64'h0, 64'h1_FFFF_FFFF_FFFF);
        free_all_slots();
        send_word(MODE_MAP, 64'h0000_0000_0000_4000, LEN_MAX, 48'h0, 1'b0, 1'b1);
        send_word(MODE_MAP, 64'h0000_0000_0000_4000, 49'h1, 48'h0, 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        hold_go <= 1'b1;
        for (int i = 0; i < 16; i++)
            send_word(MODE_MAP, root_pool[i % 4], 49'($urandom_range(1, 9000)), 48'h0,
                      1'($urandom), 1'b1);
        while (!hold_done) @(posedge aclk);
        hold_go <= 1'b0;
        wait_results_done();
    endtask

    task automatic rand_item();
        int pick;
        int lsel;
        logic [MODE_W-1:0] mode;
        logic [63:0]       root;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        lsel = $urandom_range(9);
        root = {root_pool[$urandom_range(POOL_SIZE - 1)][63:PAGE_SHIFT], 12'($urandom)};
        addr = ADDR_W'({$urandom, $urandom});
        if (lsel < 7) len = LEN_W'($urandom_range(1, 5 * PAGE_BYTES));
        else if (lsel == 7) len = LEN_W'(PAGE_BYTES * $urandom_range(1, 8));
        else if (lsel == 8) len = LEN_W'({$urandom, $urandom});
        else len = $urandom_range(1) ? LEN_MAX : '0;
        if (pick < 55) begin
            mode = MODE_MAP;
        end else if (pick < 72) begin
            mode = MODE_REL;
        end else if (pick < 88) begin
            mode = MODE_UNMAP;
            if ($urandom_range(1)) addr = win_base + ADDR_W'($urandom_range(0, 1 << 20));
        end else begin
            mode = $urandom_range(1) ? MODE_RSVD : MODE_MAP;
            case ($urandom_range(2))
                0: root = 64'h0;
                1: root = 64'($urandom_range(0, 4095));
                default: root = {$urandom, $urandom};
            endcase
        end
        send_word(mode, root, len, addr, 1'($urandom), 1'($urandom_range(99) < 85));
    endtask

    task automatic test_random(input int count, input int sp, input int rp,
                               input logic [63:0] base, input logic [63:0] wend);
        set_window(base, wend);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        for (int i = 0; i < POOL_SIZE; i++) begin
            root_pool[i] = {$urandom, $urandom};
            if (root_pool[i][63:PAGE_SHIFT] == 0) root_pool[i][PAGE_SHIFT] = 1'b1;
        end
        for (int i = 0; i < count; i++) rand_item();
        wait_results_done();
    endtask

    initial begin
        model_reset();
        for (int i = 0; i < POOL_SIZE; i++) root_pool[i] = {$urandom, $urandom} | 64'h1000;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_map_cases();
        test_release_unmap();
        test_table_full();
        test_backpressure();
        test_window_extremes();
        test_random(585, 8, 48, 64'h1_0000, 64'h1_0000 + 64 * PAGE_BYTES);
        test_random(585, 48, 8, 64'h1_0000_0000, 64'h8000_0000_0000);
        test_random(585, 0, 0, 64'h0, 64'h1_FFFF_FFFF_FFFF);
        wait_results_done();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            fails++;
        end
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pbva_pkg.sv
rtl/pbva_cell.sv
rtl/pbva_row.sv
rtl/per_space_bump_va_allocator.sv
tb/sv/tb_per_space_bump_va_allocator.sv
